>>> hdl/bfd_pkg.sv
`default_nettype none
package bfd_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  // results per frame never exceed this count
  localparam int MAX_RESULTS = 32;

  localparam logic [7:0] KEY_HI = 8'h55;
  localparam logic [7:0] KEY_LO = 8'hAA;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP = 2'd1;
  localparam logic [1:0] REG_WRITE_CMD = 2'd2;
  localparam logic [1:0] REG_ERASE_CMD = 2'd3;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_IDH,
    ST_IDL,
    ST_CMD,
    ST_REQ,
    ST_SIDH,
    ST_SIDL,
    ST_LEN,
    ST_DATA,
    ST_STOP,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic clr_frame;
    logic cap_cmd;
    logic set_unlock;
    logic cap_len;
    logic store_byte;
    logic start_emit;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic start_match;
    logic stop_match;
    logic byte_zero;
    logic key_hi;
    logic key_lo;
    logic needs_key;
    logic seen_done;
    logic empty;
    logic last_item;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/bfd_ram.sv
`default_nettype none
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> hdl/bfd_ctrl.sv
`default_nettype none
module bfd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire bfd_pkg::dp_sts_t sts,
  output bfd_pkg::dp_cmd_t      cmd
);
  import bfd_pkg::*;

  state_t state_r, state_nxt;
  logic   in_ready;
  logic   in_xact;
  logic   out_xact;

  assign in_ready = (state_r != ST_READ) && (state_r != ST_SHOW);
  assign in_xact  = in_tvalid && in_ready;
  assign out_xact = (state_r == ST_SHOW) && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: if (in_xact && sts.start_match) state_nxt = ST_IDH;
      ST_IDH:  if (in_xact) state_nxt = sts.byte_zero ? ST_IDL : ST_HUNT;
      ST_IDL:  if (in_xact) state_nxt = sts.byte_zero ? ST_CMD : ST_HUNT;
      ST_CMD:  if (in_xact) state_nxt = ST_REQ;
      ST_REQ:  if (in_xact) state_nxt = sts.byte_zero ? ST_SIDH : ST_HUNT;
      ST_SIDH: begin
        if (in_xact) begin
          if (sts.needs_key) state_nxt = sts.key_hi ? ST_SIDL : ST_HUNT;
          else               state_nxt = sts.byte_zero ? ST_SIDL : ST_HUNT;
        end
      end
      ST_SIDL: begin
        if (in_xact) begin
          if (sts.needs_key) state_nxt = sts.key_lo ? ST_LEN : ST_HUNT;
          else               state_nxt = sts.byte_zero ? ST_LEN : ST_HUNT;
        end
      end
      ST_LEN:  if (in_xact) state_nxt = sts.byte_zero ? ST_STOP : ST_DATA;
      ST_DATA: if (in_xact && sts.seen_done) state_nxt = ST_STOP;
      ST_STOP: begin
        if (in_xact) begin
          if (!sts.stop_match) state_nxt = ST_HUNT;
          else if (sts.empty)  state_nxt = ST_SHOW;
          else                 state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (out_xact) state_nxt = sts.last_item ? ST_HUNT : ST_READ;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = in_ready;
    out_tvalid = (state_r == ST_SHOW);
    case (state_r)
      ST_HUNT: cmd.clr_frame  = in_xact && sts.start_match;
      ST_CMD:  cmd.cap_cmd    = in_xact;
      ST_SIDL: cmd.set_unlock = in_xact && sts.needs_key && sts.key_lo;
      ST_LEN:  cmd.cap_len    = in_xact;
      ST_DATA: cmd.store_byte = in_xact;
      ST_STOP: cmd.start_emit = in_xact && sts.stop_match;
      ST_SHOW: cmd.advance    = out_xact && !sts.last_item;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/bfd_datapath.sv
`default_nettype none
module bfd_datapath #(
  parameter int BUFFER_DEPTH = bfd_pkg::BUF_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic [7:0]       rx_byte,
  input  wire bfd_pkg::dp_cmd_t cmd,
  output bfd_pkg::dp_sts_t      sts,
  output logic      [7:0]       command,
  output logic      [7:0]       frame_length,
  output logic                  unlocked,
  output logic                  has_data,
  output logic      [7:0]       payload_byte,
  output logic      [4:0]       byte_index,
  output logic                  truncated,
  output logic                  last
);
  import bfd_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CAP = (BUFFER_DEPTH < MAX_RESULTS) ? BUFFER_DEPTH : MAX_RESULTS;
  localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);
  localparam logic [7:0] CAP_B = 8'(CAP);

  logic [7:0] start_r, stop_r, wcmd_r, ecmd_r;
  logic [7:0] held_cmd_r, held_len_r, seen_r;
  logic       unlock_r;
  logic [4:0] k_r;
  logic [7:0] seen_inc;
  logic [7:0] emit_cnt;
  logic [6:0] k_wide;
  logic [7:0] rd_data;
  logic       wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
      wcmd_r  <= '0;
      ecmd_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START:     start_r <= cfg_data;
        REG_STOP:      stop_r  <= cfg_data;
        REG_WRITE_CMD: wcmd_r  <= cfg_data;
        REG_ERASE_CMD: ecmd_r  <= cfg_data;
        default:       start_r <= start_r;
      endcase
    end
  end

  assign seen_inc = seen_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cmd_r <= '0;
      held_len_r <= '0;
      unlock_r   <= 1'b0;
      seen_r     <= '0;
      k_r        <= '0;
    end else begin
      if (cmd.clr_frame) begin
        held_len_r <= '0;
        unlock_r   <= 1'b0;
      end
      if (cmd.cap_cmd)    held_cmd_r <= rx_byte;
      if (cmd.set_unlock) unlock_r   <= 1'b1;
      if (cmd.cap_len) begin
        held_len_r <= rx_byte;
        seen_r     <= '0;
      end
      if (cmd.store_byte) seen_r <= seen_inc;
      if (cmd.start_emit) k_r <= '0;
      else if (cmd.advance) k_r <= k_r + 5'd1;
    end
  end

  // drop payload bytes past the end of the store, but keep counting them
  assign wr_en  = cmd.store_byte && (seen_r < DEPTH_B);
  assign k_wide = {2'b00, k_r};

  bfd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (seen_r[AW-1:0]),
    .wr_data (rx_byte),
    .rd_addr (k_wide[AW-1:0]),
    .rd_data (rd_data)
  );

  assign emit_cnt = (held_len_r > CAP_B) ? CAP_B : held_len_r;

  assign sts.start_match = (rx_byte == start_r);
  assign sts.stop_match  = (rx_byte == stop_r);
  assign sts.byte_zero   = (rx_byte == ZERO_BYTE);
  assign sts.key_hi      = (rx_byte == KEY_HI);
  assign sts.key_lo      = (rx_byte == KEY_LO);
  assign sts.needs_key   = (held_cmd_r == wcmd_r) || (held_cmd_r == ecmd_r);
  assign sts.seen_done   = (seen_inc == held_len_r);
  assign sts.empty       = (held_len_r == ZERO_BYTE);
  assign sts.last_item   = sts.empty || (({3'b000, k_r} + 8'd1) == emit_cnt);

  assign command      = held_cmd_r;
  assign frame_length = held_len_r;
  assign unlocked     = unlock_r;
  assign has_data     = !sts.empty;
  assign payload_byte = sts.empty ? ZERO_BYTE : rd_data;
  assign byte_index   = sts.empty ? 5'd0 : k_r;
  assign truncated    = (held_len_r > emit_cnt);
  assign last         = sts.last_item;

endmodule
`default_nettype wire

>>> hdl/boot_frame_deframer.sv
// Header and payload bytes: one input transaction per cycle, no result.
// On a matching stop byte the frame goes out as a burst with input held off:
// the first result is offered after a store read (in the cycle after the stop
// byte for an empty frame); each further result again goes store read, then output.
// Reset is synchronous, active low: parser back to start-byte hunt, config and
// frame registers to zero; the payload store is not cleared.
`default_nettype none
module boot_frame_deframer #(
  parameter int BUFFER_DEPTH = bfd_pkg::BUF_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] command, [15:8] frame_length, [16] unlocked, [24:17] payload_byte,
  // [29:25] byte_index, [30] truncated, [31] zero
  output logic      [31:0] out_tdata,
  output logic      [0:0]  out_tuser,  // [0] has_data
  output logic             out_tlast
);
  import bfd_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [7:0] command, frame_length, payload_byte;
  logic [4:0] byte_index;
  logic       unlocked, has_data, truncated, last;

  bfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bfd_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .command      (command),
    .frame_length (frame_length),
    .unlocked     (unlocked),
    .has_data     (has_data),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .truncated    (truncated),
    .last         (last)
  );

  assign out_tdata = {1'b0, truncated, byte_index, payload_byte, unlocked,
                      frame_length, command};
  assign out_tuser = has_data;
  assign out_tlast = last;

endmodule
`default_nettype wire

>>> tb/boot_frame_deframer_tb.sv
`default_nettype none
module boot_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int DEPTH = BUF_DEPTH_DEF;
  localparam int STALL_LIMIT = 500;

  typedef struct {
    logic [7:0] command;
    logic [7:0] frame_length;
    logic       unlocked;
    logic       has_data;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       truncated;
    logic       last;
  } frame_result_t;

  class frame_scoreboard;
    bit [7:0] start_code, stop_code, write_cmd, erase_cmd;
    state_t phase = ST_HUNT;
    bit [7:0] cmd_held, len_held, seen;
    bit unlock_held;
    bit [7:0] store [DEPTH];
    frame_result_t expected_q[$];
    int errors, bytes_in, results_in, frames_out, empty_frames, trunc_frames, unlocked_frames;

    function void set_reg(logic [1:0] idx, bit [7:0] v);
      case (idx)
        REG_START: start_code = v;
        REG_STOP: stop_code = v;
        REG_WRITE_CMD: write_cmd = v;
        REG_ERASE_CMD: erase_cmd = v;
        default: ;
      endcase
    endfunction

    function bit key_needed();
      return cmd_held == write_cmd || cmd_held == erase_cmd;
    endfunction

    // Advance the parser by one received byte; queue the frame on a good stop.
    function void note_byte(bit [7:0] b);
      int stored;
      frame_result_t r;
      bytes_in++;
      case (phase)
        ST_HUNT: begin
          if (b == start_code) begin
            phase = ST_IDH;
            len_held = 0;
            unlock_held = 0;
          end
        end
        ST_IDH: phase = (b == ZERO_BYTE) ? ST_IDL : ST_HUNT;
        ST_IDL: phase = (b == ZERO_BYTE) ? ST_CMD : ST_HUNT;
        ST_CMD: begin
          cmd_held = b;
          phase = ST_REQ;
        end
        ST_REQ: phase = (b == ZERO_BYTE) ? ST_SIDH : ST_HUNT;
        ST_SIDH: phase = (b == (key_needed() ? KEY_HI : ZERO_BYTE)) ? ST_SIDL : ST_HUNT;
        ST_SIDL: begin
          if (b == (key_needed() ? KEY_LO : ZERO_BYTE)) begin
            if (key_needed()) unlock_held = 1;
            phase = ST_LEN;
          end else begin
            phase = ST_HUNT;
          end
        end
        ST_LEN: begin
          len_held = b;
          seen = 0;
          phase = (b != ZERO_BYTE) ? ST_DATA : ST_STOP;
        end
        ST_DATA: begin
          // drop bytes past the buffer but keep counting them
          if (seen < DEPTH) store[seen] = b;
          seen++;
          if (seen == len_held) phase = ST_STOP;
        end
        ST_STOP: begin
          if (b == stop_code) begin
            stored = len_held;
            if (stored > DEPTH) stored = DEPTH;
            if (stored > MAX_RESULTS) stored = MAX_RESULTS;
            r.command = cmd_held;
            r.frame_length = len_held;
            r.unlocked = unlock_held;
            r.truncated = (len_held > stored);
            frames_out++;
            if (r.truncated) trunc_frames++;
            if (unlock_held) unlocked_frames++;
            if (stored == 0) begin
              empty_frames++;
              r.has_data = 0;
              r.payload_byte = 0;
              r.byte_index = 0;
              r.last = 1;
              expected_q.push_back(r);
            end else begin
              for (int k = 0; k < stored; k++) begin
                r.has_data = 1;
                r.payload_byte = store[k];
                r.byte_index = k[4:0];
                r.last = (k == stored - 1);
                expected_q.push_back(r);
              end
            end
          end
          phase = ST_HUNT;
        end
        default: phase = ST_HUNT;
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [31:0] d, logic has, logic l);
      frame_result_t want;
      results_in++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, %s %h %b %b",
                 $time, "got data/has_data/last", d, has, l);
        return;
      end
      want = expected_q.pop_front();
      compare("command", want.command, d[7:0]);
      compare("frame_length", want.frame_length, d[15:8]);
      compare("unlocked", 8'(want.unlocked), 8'(d[16]));
      compare("has_data", 8'(want.has_data), 8'(has));
      compare("payload_byte", want.payload_byte, d[24:17]);
      compare("byte_index", 8'(want.byte_index), 8'(d[29:25]));
      compare("truncated", 8'(want.truncated), 8'(d[30]));
      compare("last", 8'(want.last), 8'(l));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_START;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] command, [15:8] frame_length, [16] unlocked, [24:17] payload_byte,
  // [29:25] byte_index, [30] truncated, [31] zero
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;          // [0] has_data
  logic        out_tlast;

  frame_scoreboard sb = new();
  bit steady = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  int settings_used = 0;

  boot_frame_deframer dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_byte(bit [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    sent_count++;
  endtask

  // Hold input until every queued result is out, then let the parser settle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(bit [7:0] s, bit [7:0] p, bit [7:0] w, bit [7:0] e);
    logic [1:0] idx [4];
    bit [7:0] vals [4];
    idx = '{REG_START, REG_STOP, REG_WRITE_CMD, REG_ERASE_CMD};
    vals = '{s, p, w, e};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int draw_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 31);
    return $urandom_range(32, 40);
  endfunction

  task automatic send_frame(int len, bit clean);
    bit [7:0] cmd;
    bit key;
    bit [7:0] frame[$];
    int flaw;
    int at;
    case ($urandom_range(0, 2))
      0: cmd = sb.write_cmd;
      1: cmd = sb.erase_cmd;
      default: cmd = 8'($urandom);
    endcase
    key = (cmd == sb.write_cmd) || (cmd == sb.erase_cmd);
    frame = {sb.start_code, ZERO_BYTE, ZERO_BYTE, cmd, ZERO_BYTE,
             key ? KEY_HI : ZERO_BYTE, key ? KEY_LO : ZERO_BYTE, 8'(len)};
    repeat (len) frame.push_back(8'($urandom));
    frame.push_back(sb.stop_code);
    flaw = clean ? 0 : $urandom_range(0, 9);
    if (flaw == 7) begin
      // corrupt one header byte; the tail still goes out as line noise
      case ($urandom_range(0, 4))
        0: at = 1;
        1: at = 2;
        2: at = 4;
        3: at = 5;
        default: at = 6;
      endcase
      frame[at] = frame[at] ^ 8'($urandom_range(1, 255));
    end else if (flaw == 8) begin
      frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'($urandom_range(1, 255));
    end else if (flaw == 9) begin
      repeat ($urandom_range(1, 6)) frame.push_front(8'($urandom));
    end
    steady = ($urandom_range(0, 5) == 0);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0], out_tlast);
  end

  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [7:0] opening[$];
    // keyed write command with an empty payload, a header that breaks on a
    // start-valued id byte, then a plain command with a two-byte payload
    opening = {8'h7E, ZERO_BYTE, ZERO_BYTE, 8'h10, ZERO_BYTE, KEY_HI, KEY_LO,
               ZERO_BYTE, 8'h81,
               8'h7E, ZERO_BYTE, 8'h7E,
               8'h7E, ZERO_BYTE, ZERO_BYTE, 8'hFF, ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, 8'h02,
               ZERO_BYTE, 8'hFF, 8'h81};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(8'h7E, 8'h81, 8'h10, 8'h20);
    foreach (opening[i]) send_byte(opening[i]);

    apply_setting(ZERO_BYTE, 8'hFF, 8'hFF, ZERO_BYTE);
    send_frame(130, 1'b1);
    while (sent_count < 200) send_frame(draw_length(), 1'b0);

    apply_setting(8'hFF, ZERO_BYTE, ZERO_BYTE, 8'hFF);
    while (sent_count < 260) send_frame(draw_length(), 1'b0);

    // both flash commands share one code
    apply_setting(8'hC3, 8'h3C, 8'h5A, 8'h5A);
    while (sent_count < 320) send_frame(draw_length(), 1'b0);

    apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    while (sent_count < 350) send_frame(draw_length(), 1'b0);

    settle();
    repeat (4) @(posedge clk);

    $display("Run covered %0d received bytes and %0d results from %0d frames",
             sb.bytes_in, sb.results_in, sb.frames_out);
    $display("(%0d empty, %0d truncated, %0d unlocked) over %0d register settings.",
             sb.empty_frames, sb.trunc_frames, sb.unlocked_frames, settings_used);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/bfd_pkg.sv
hdl/bfd_ram.sv
hdl/bfd_ctrl.sv
hdl/bfd_datapath.sv
hdl/boot_frame_deframer.sv
tb/boot_frame_deframer_tb.sv
